// ----- hdl/psb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psb_pkg
// Shared widths, codes and types of the palette scale blit unit.
// ----------------------------------------------------------------------------
package psb_pkg;

  localparam int PALETTE_DEPTH_DEF = 256;
  localparam int MAX_SCALE_DEF     = 8;
  localparam int MAX_DIM_DEF       = 1024;

  localparam int SCALE_W  = 4;
  localparam int OFS_W    = 10;
  localparam int DIM_W    = 11;
  localparam int COORD_W  = 10;
  localparam int CODE_W   = 8;
  localparam int COLOUR_W = 16;
  localparam int ADDR_W   = 20;
  localparam int POS_W    = 14;
  localparam int CNT_W    = 4;

  localparam int QUEUE_DEPTH = 4;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;
  localparam int S_TDATA_W  = 64;
  localparam int M_TDATA_W  = 40;

  localparam logic OP_PALETTE = 1'b0;
  localparam logic OP_DRAW    = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_SCALE_X     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_Y     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DEST_WIDTH  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DEST_HEIGHT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SWAP_BYTES  = 3'd6;

  // effective settings, scales and canvas size already saturated
  typedef struct packed {
    logic [SCALE_W-1:0] scale_x;
    logic [SCALE_W-1:0] scale_y;
    logic [OFS_W-1:0]   offset_x;
    logic [OFS_W-1:0]   offset_y;
    logic [DIM_W-1:0]   width;
    logic [DIM_W-1:0]   height;
    logic               swap;
  } cfg_t;

  // one clipped block of writes
  typedef struct packed {
    logic [ADDR_W-1:0]   addr;
    logic [CNT_W-1:0]    nx;
    logic [CNT_W-1:0]    ny;
    logic [COLOUR_W-1:0] colour;
  } entry_t;

endpackage

// ----- hdl/psb_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psb_ram
// Generic single write port RAM with registered read.
// ----------------------------------------------------------------------------
module psb_ram #(
  parameter int Width = 16,
  parameter int Depth = 256,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AddrW-1:0] waddr,
  input  logic [Width-1:0] wdata,
  input  logic             re,
  input  logic [AddrW-1:0] raddr,
  output logic [Width-1:0] rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hdl/psb_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psb_front
// Accepts beats, writes the palette, drops transparent pixels, looks up the
// colour and clips the replicated block to the canvas.
// ----------------------------------------------------------------------------
module psb_front #(
  parameter int PaletteDepth = psb_pkg::PALETTE_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  psb_pkg::cfg_t                cfg,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [psb_pkg::S_TDATA_W-1:0] s_tdata,
  input  logic                         s_tuser,
  output logic                         push_valid,
  output psb_pkg::entry_t              push_entry,
  input  logic                         push_ready
);
  import psb_pkg::*;

  localparam int AW = (PaletteDepth > 1) ? $clog2(PaletteDepth) : 1;
  localparam int PW = POS_W + DIM_W;

  logic [CODE_W-1:0]   entry_number;
  logic [COLOUR_W-1:0] entry_colour;
  logic [COORD_W-1:0]  src_col;
  logic [COORD_W-1:0]  src_row;
  logic [CODE_W-1:0]   pixel_code;
  logic                transp_enable;
  logic [CODE_W-1:0]   transp_code;

  logic accept, is_draw, transparent, load_b, ram_we;
  logic [POS_W-1:0] x0, y0;
  logic [COLOUR_W-1:0] rdata, colour;

  logic             b_valid, b_code_ok, b_free, keep;
  logic [POS_W-1:0] b_x0, b_y0;
  logic [POS_W-1:0] wext, hext, x_room, y_room;
  logic [CNT_W-1:0] nx, ny;
  logic [PW-1:0]    prod;

  assign entry_number  = s_tdata[7:0];
  assign entry_colour  = s_tdata[23:8];
  assign src_col       = s_tdata[33:24];
  assign src_row       = s_tdata[43:34];
  assign pixel_code    = s_tdata[51:44];
  assign transp_enable = s_tdata[52];
  assign transp_code   = s_tdata[60:53];

  assign accept      = s_tvalid && s_tready;
  assign is_draw     = (s_tuser == OP_DRAW);
  assign transparent = transp_enable && (pixel_code == transp_code);
  assign ram_we      = accept && !is_draw && (int'(entry_number) < PaletteDepth);
  assign load_b      = accept && is_draw && !transparent;

  assign x0 = POS_W'(cfg.offset_x) + POS_W'(src_col) * POS_W'(cfg.scale_x);
  assign y0 = POS_W'(cfg.offset_y) + POS_W'(src_row) * POS_W'(cfg.scale_y);

  psb_ram #(
    .Width(COLOUR_W),
    .Depth(PaletteDepth)
  ) u_palette (
    .clk  (clk),
    .we   (ram_we),
    .waddr(entry_number[AW-1:0]),
    .wdata(entry_colour),
    .re   (load_b),
    .raddr(pixel_code[AW-1:0]),
    .rdata(rdata)
  );

  // clip the block against the canvas, pick its colour and form the row offset
  always_comb begin
    wext   = POS_W'(cfg.width);
    hext   = POS_W'(cfg.height);
    x_room = wext - b_x0;
    y_room = hext - b_y0;
    if (b_x0 >= wext) begin
      nx = '0;
    end else if (x_room < POS_W'(cfg.scale_x)) begin
      nx = CNT_W'(x_room);
    end else begin
      nx = CNT_W'(cfg.scale_x);
    end
    if (b_y0 >= hext) begin
      ny = '0;
    end else if (y_room < POS_W'(cfg.scale_y)) begin
      ny = CNT_W'(y_room);
    end else begin
      ny = CNT_W'(cfg.scale_y);
    end
    colour = b_code_ok ? rdata : '0;
    if (cfg.swap) begin
      colour = {colour[7:0], colour[15:8]};
    end
    prod = PW'(b_y0) * PW'(cfg.width);
  end

  assign keep       = (nx != '0) && (ny != '0);
  assign push_valid = b_valid && keep;
  assign b_free     = !b_valid || !keep || push_ready;
  assign s_tready   = b_free;

  assign push_entry.addr   = prod[ADDR_W-1:0] + ADDR_W'(b_x0);
  assign push_entry.nx     = nx;
  assign push_entry.ny     = ny;
  assign push_entry.colour = colour;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_free) begin
      b_valid <= load_b;
    end
  end

  always_ff @(posedge clk) begin
    if (load_b) begin
      b_x0      <= x0;
      b_y0      <= y0;
      b_code_ok <= (int'(pixel_code) < PaletteDepth);
    end
  end

endmodule

// ----- hdl/psb_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psb_queue
// Short queue of clipped blocks between front and back.
// ----------------------------------------------------------------------------
module psb_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  input  psb_pkg::entry_t push_entry,
  output logic            push_ready,
  output logic            pop_valid,
  output psb_pkg::entry_t pop_entry,
  input  logic            pop
);
  import psb_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

  entry_t              slots [QUEUE_DEPTH];
  logic [PTR_W-1:0]    wr_ptr, rd_ptr;
  logic [CNT_QW-1:0]   count;
  logic                do_push, do_pop;

  assign push_ready = (count != CNT_QW'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_entry  = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!do_push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

endmodule

// ----- hdl/psb_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psb_back
// Walks each clipped block row by row, a write beat per cycle unless stalled.
// ----------------------------------------------------------------------------
module psb_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [psb_pkg::DIM_W-1:0]     width,
  input  logic                          pop_valid,
  input  psb_pkg::entry_t               pop_entry,
  output logic                          pop,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [psb_pkg::M_TDATA_W-1:0] m_tdata,
  output logic                          m_tlast
);
  import psb_pkg::*;

  logic                active, out_load, emit, last_beat;
  logic [ADDR_W-1:0]   addr, row_addr, next_row;
  logic [CNT_W-1:0]    xleft, yleft, nx_m1;
  logic [COLOUR_W-1:0] colour;
  logic [ADDR_W-1:0]   out_addr;
  logic [COLOUR_W-1:0] out_colour;

  assign out_load  = !m_tvalid || m_tready;
  assign emit      = active && out_load;
  assign last_beat = (xleft == '0) && (yleft == '0);
  assign pop       = pop_valid && (!active || (emit && last_beat));
  assign next_row  = row_addr + ADDR_W'(width);

  assign m_tdata = {{(M_TDATA_W - ADDR_W - COLOUR_W){1'b0}}, out_colour, out_addr};

  always_ff @(posedge clk) begin
    if (rst) begin
      active   <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (out_load) begin
        m_tvalid <= active;
      end
      if (pop) begin
        active <= 1'b1;
      end else if (emit && last_beat) begin
        active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_addr   <= addr;
      out_colour <= colour;
      m_tlast    <= last_beat;
    end
    if (pop) begin
      addr     <= pop_entry.addr;
      row_addr <= pop_entry.addr;
      xleft    <= pop_entry.nx - 1'b1;
      nx_m1    <= pop_entry.nx - 1'b1;
      yleft    <= pop_entry.ny - 1'b1;
      colour   <= pop_entry.colour;
    end else if (emit) begin
      if (xleft == '0) begin
        row_addr <= next_row;
        addr     <= next_row;
        xleft    <= nx_m1;
        yleft    <= yleft - 1'b1;
      end else begin
        addr  <= addr + 1'b1;
        xleft <= xleft - 1'b1;
      end
    end
  end

endmodule

// ----- hdl/palette_scale_blit_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// palette_scale_blit_unit
// Palette lookup with integer upscaling and canvas clipping, RGB565 output.
// ----------------------------------------------------------------------------
// A palette write, a skipped pixel and a fully clipped pixel leave nothing. A
// drawn pixel leaves as its kept copies, one write beat per cycle from the
// back-end address walker while m_tready is high: up to four for a 2x2
// upscale. The front end accepts one beat per cycle while a four entry block
// queue has room; the first write beat of a pixel passes the block register,
// a queue slot, the walker and the output register before it is offered. The
// palette holds no reset value: draw only entries already written.
module palette_scale_blit_unit #(
  parameter int PaletteDepth = psb_pkg::PALETTE_DEPTH_DEF,
  parameter int MaxScale     = psb_pkg::MAX_SCALE_DEF,
  parameter int MaxDim       = psb_pkg::MAX_DIM_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [psb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [psb_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // entry_number, entry_colour, src_col, src_row, pixel_code,
  // transp_enable, transp_code
  input  logic [psb_pkg::S_TDATA_W-1:0]  s_tdata,
  // operation
  input  logic                           s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // fb_address, pixel_colour
  output logic [psb_pkg::M_TDATA_W-1:0]  m_tdata,
  // run_last
  output logic                           m_tlast
);
  import psb_pkg::*;

  logic [SCALE_W-1:0] scale_x, scale_y;
  logic [OFS_W-1:0]   offset_x, offset_y;
  logic [DIM_W-1:0]   dest_width, dest_height;
  logic               swap_bytes;
  cfg_t               cfg;

  logic   push_valid, push_ready, pop_valid, pop;
  entry_t push_entry, pop_entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_x     <= SCALE_W'(1);
      scale_y     <= SCALE_W'(1);
      offset_x    <= '0;
      offset_y    <= '0;
      dest_width  <= DIM_W'(320);
      dest_height <= DIM_W'(240);
      swap_bytes  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SCALE_X:     scale_x     <= cfg_data[SCALE_W-1:0];
        REG_SCALE_Y:     scale_y     <= cfg_data[SCALE_W-1:0];
        REG_OFFSET_X:    offset_x    <= cfg_data[OFS_W-1:0];
        REG_OFFSET_Y:    offset_y    <= cfg_data[OFS_W-1:0];
        REG_DEST_WIDTH:  dest_width  <= cfg_data[DIM_W-1:0];
        REG_DEST_HEIGHT: dest_height <= cfg_data[DIM_W-1:0];
        REG_SWAP_BYTES:  swap_bytes  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // saturate scales to 1..MaxScale and canvas to MaxDim
  always_comb begin
    cfg.scale_x = scale_x;
    if (scale_x == '0) begin
      cfg.scale_x = SCALE_W'(1);
    end else if (int'(scale_x) > MaxScale) begin
      cfg.scale_x = SCALE_W'(MaxScale);
    end
    cfg.scale_y = scale_y;
    if (scale_y == '0) begin
      cfg.scale_y = SCALE_W'(1);
    end else if (int'(scale_y) > MaxScale) begin
      cfg.scale_y = SCALE_W'(MaxScale);
    end
    cfg.width    = (int'(dest_width) > MaxDim) ? DIM_W'(MaxDim) : dest_width;
    cfg.height   = (int'(dest_height) > MaxDim) ? DIM_W'(MaxDim) : dest_height;
    cfg.offset_x = offset_x;
    cfg.offset_y = offset_y;
    cfg.swap     = swap_bytes;
  end

  psb_front #(
    .PaletteDepth(PaletteDepth)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .push_valid(push_valid),
    .push_entry(push_entry),
    .push_ready(push_ready)
  );

  psb_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(push_valid),
    .push_entry(push_entry),
    .push_ready(push_ready),
    .pop_valid (pop_valid),
    .pop_entry (pop_entry),
    .pop       (pop)
  );

  psb_back u_back (
    .clk      (clk),
    .rst      (rst),
    .width    (cfg.width),
    .pop_valid(pop_valid),
    .pop_entry(pop_entry),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule
